### sv/assert_macros.svh
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

### sv/sgne_pkg.sv
// Types and constants of the step grid to note events block.
package sgne_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_CELL = 2'd0,
      CMD_WRITE_LANE = 2'd1,
      CMD_LOAD_ID    = 2'd2,
      CMD_RENDER     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_STEP_TICKS    = 3'd0,
      REG_STEP_COUNT    = 3'd1,
      REG_PATTERN_START = 3'd2,
      REG_GATE_RATIO    = 3'd3,
      REG_ACCENT_VEL    = 3'd4,
      REG_STEP_VEL      = 3'd5,
      REG_MIDI_CHANNEL  = 3'd6,
      REG_LANE_COUNT    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SCAN,
      S_DRAIN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  lane_sel;
      logic [3:0]  step_sel;
      logic        active_in;
      logic        accent_in;
      logic        slide_in;
      logic [6:0]  note_in;
      logic [47:0] id_value;
   } req_type;

   typedef struct packed {
      logic [31:0] start_tick;
      logic [31:0] end_tick;
      logic [3:0]  channel_out;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic [47:0] note_id;
      logic        last;
   } rsp_type;

   // Per-cell attributes kept in the cell memory.
   typedef struct packed {
      logic       accent;
      logic       slide;
      logic [6:0] note;
   } cell_type;

   // One entry of the sorted note list built during a render.
   typedef struct packed {
      logic [6:0]  note;
      logic        accent;
      logic        slide;
      logic [47:0] id;
   } slot_type;

   localparam int CELL_W   = $bits(cell_type);
   localparam int LEN_W    = 18;
   localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

endpackage

### sv/sgne_ram.sv
// Generic simple dual-port RAM with registered read.
module sgne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### sv/step_grid_to_note_events.sv
// Step grid to note events: top level with grid storage, render sequencer and output register.
// Write, lane-note and id-load commands, and renders that emit nothing because the step is out
// of use or the tick, step or lane count is zero, leave the sequencer idle. Any other render
// holds the input off through two phases of timing arithmetic on the shared multiplier, one
// scan and insertion step per lane in use, a drain step, one step per emitted note and a closing
// step. The lane scan and the emission set how long this takes, and a waiting result that is
// not taken stalls the emission. Results leave through an output register, so a new word can be
// accepted while the final note still waits to be taken.
`include "assert_macros.svh"

module step_grid_to_note_events
   import sgne_pkg::*;
#(
   parameter int MAX_LANES = 8,
   parameter int MAX_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int NL_W  = $clog2(MAX_LANES + 1);
   localparam int NS_W  = $clog2(MAX_STEPS + 1);
   localparam int CELLS = MAX_LANES * MAX_STEPS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   // Configuration registers.
   logic [15:0] step_ticks_ff;
   logic [4:0]  step_count_ff;
   logic [31:0] pattern_start_ff;
   logic [9:0]  gate_ratio_ff;
   logic [6:0]  accent_vel_ff;
   logic [6:0]  step_vel_ff;
   logic [3:0]  channel_ff;
   logic [3:0]  lane_count_ff;

   // Grid state.
   logic [MAX_STEPS-1:0] active_ff [MAX_LANES];
   logic [6:0]           lane_note_ff [MAX_LANES];
   logic [47:0]          next_id_ff;

   // Render state.
   state_type         state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [3:0]        step_ff, step_in;
   logic [NS_W-1:0]   ns_ff, ns_in;
   logic [NL_W-1:0]   nl_ff, nl_in;
   logic [NL_W-1:0]   lane_ff, lane_in;
   logic [47:0]       base_ff, base_in;
   logic [31:0]       start_ff, start_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  slide_len_ff, slide_len_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [47:0]       pend_id_ff, pend_id_in;
   logic [6:0]        pend_note_ff, pend_note_in;
   slot_type          slot_ff [MAX_LANES];
   slot_type          slot_in [MAX_LANES];
   logic [NL_W-1:0]   cnt_ff, cnt_in;
   logic [NL_W-1:0]   emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Cell memory.
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   cell_type          ram_wdata;
   cell_type          ram_rdata;

   logic              req_fire;
   logic              lane_ok;
   logic              step_ok;
   logic [NS_W-1:0]   eff_ns;
   logic [NL_W-1:0]   eff_nl;
   logic              render_empty;

   // Shared multiplier.
   logic [9:0]        mul_b;
   logic [25:0]       mul_p;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lane_ok = ({2'b0, req_data.lane_sel} < 5'(MAX_LANES));
   assign step_ok = ({3'b0, req_data.step_sel} < 7'(MAX_STEPS));

   assign eff_ns = (int'(step_count_ff) > MAX_STEPS) ? NS_W'(MAX_STEPS) : NS_W'(step_count_ff);
   assign eff_nl = (int'(lane_count_ff) > MAX_LANES) ? NL_W'(MAX_LANES) : NL_W'(lane_count_ff);
   assign render_empty = (step_ticks_ff == 16'd0) || (eff_ns == '0) || (eff_nl == '0)
                      || (int'(req_data.step_sel) >= int'(eff_ns));

   assign mul_b = phase_ff ? gate_ratio_ff : {6'd0, step_ff};
   assign mul_p = step_ticks_ff * mul_b;

   assign ram_we    = req_fire && (req_data.cmd == CMD_WRITE_CELL) && lane_ok && step_ok;
   assign ram_waddr = AW'(int'(req_data.lane_sel) * MAX_STEPS + int'(req_data.step_sel));
   assign ram_wdata = '{accent: req_data.accent_in, slide: req_data.slide_in,
                        note: req_data.note_in};
   assign ram_raddr = AW'(int'(lane_ff[LW-1:0]) * MAX_STEPS + int'(step_ff));

   sgne_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Configuration and grid writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff    <= 16'd120;
         step_count_ff    <= 5'd16;
         pattern_start_ff <= 32'd0;
         gate_ratio_ff    <= 10'd230;
         accent_vel_ff    <= 7'd127;
         step_vel_ff      <= 7'd100;
         channel_ff       <= 4'd0;
         lane_count_ff    <= 4'd1;
         next_id_ff       <= 48'd0;
         for (int i = 0; i < MAX_LANES; i++) begin
            active_ff[i]    <= '0;
            lane_note_ff[i] <= 7'd0;
         end
      end else begin
         if (csr_we) begin
            unique case (reg_index_type'(csr_addr))
               REG_STEP_TICKS:    step_ticks_ff    <= csr_wdata[15:0];
               REG_STEP_COUNT:    step_count_ff    <= csr_wdata[4:0];
               REG_PATTERN_START: pattern_start_ff <= csr_wdata;
               REG_GATE_RATIO:    gate_ratio_ff    <= csr_wdata[9:0];
               REG_ACCENT_VEL:    accent_vel_ff    <= csr_wdata[6:0];
               REG_STEP_VEL:      step_vel_ff      <= csr_wdata[6:0];
               REG_MIDI_CHANNEL:  channel_ff       <= csr_wdata[3:0];
               REG_LANE_COUNT:    lane_count_ff    <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (ram_we) begin
            active_ff[LW'(req_data.lane_sel)][SW'(req_data.step_sel)] <= req_data.active_in;
         end
         if (req_fire && (req_data.cmd == CMD_WRITE_LANE) && lane_ok) begin
            lane_note_ff[LW'(req_data.lane_sel)] <= req_data.note_in;
         end
         if (req_fire && (req_data.cmd == CMD_LOAD_ID)) begin
            next_id_ff <= req_data.id_value;
         end
      end
   end

   // Render sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         emit_ff       <= '0;
         lane_ff       <= '0;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         emit_ff       <= emit_in;
         lane_ff       <= lane_in;
         phase_ff      <= phase_in;
      end
      step_ff      <= step_in;
      ns_ff        <= ns_in;
      nl_ff        <= nl_in;
      base_ff      <= base_in;
      start_ff     <= start_in;
      len_ff       <= len_in;
      slide_len_ff <= slide_len_in;
      pend_id_ff   <= pend_id_in;
      pend_note_ff <= pend_note_in;
      rsp_ff       <= rsp_in;
      for (int i = 0; i < MAX_LANES; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_comb begin
      logic [MAX_STEPS-1:0] row;
      logic [NS_W-1:0]      used_cnt;
      logic [NS_W-1:0]      below_cnt;
      logic [MAX_LANES-1:0] le;
      logic [6:0]           new_note;
      slot_type             new_slot;
      slot_type             cur;
      logic [32:0]          sum33;
      logic [26:0]          rounded;
      logic [LEN_W-1:0]     glen;
      logic [17:0]          tri_ticks;

      state_in      = state_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      ns_in         = ns_ff;
      nl_in         = nl_ff;
      lane_in       = lane_ff;
      base_in       = base_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      slide_len_in  = slide_len_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_note_in  = pend_note_ff;
      cnt_in        = cnt_ff;
      emit_in       = emit_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < MAX_LANES; i++) begin
         slot_in[i] = slot_ff[i];
      end

      // Active flags of the lane being scanned, counted over steps in use and earlier steps.
      row       = active_ff[lane_ff[LW-1:0]];
      used_cnt  = '0;
      below_cnt = '0;
      for (int s = 0; s < MAX_STEPS; s++) begin
         if (row[s] && (s < int'(ns_ff))) begin
            used_cnt = used_cnt + NS_W'(1);
         end
         if (row[s] && (s < int'(step_ff))) begin
            below_cnt = below_cnt + NS_W'(1);
         end
      end

      // Stable insertion of the cell read last cycle into the sorted list.
      new_note = (ram_rdata.note != 7'd0) ? ram_rdata.note : pend_note_ff;
      new_slot = '{note: new_note, accent: ram_rdata.accent, slide: ram_rdata.slide,
                   id: pend_id_ff};
      for (int i = 0; i < MAX_LANES; i++) begin
         le[i] = (i < int'(cnt_ff)) && (slot_ff[i].note <= new_note);
      end

      sum33     = {1'b0, pattern_start_ff} + {7'd0, mul_p};
      rounded   = {1'b0, mul_p} + 27'd128;
      glen      = LEN_W'(rounded[26:8]);
      tri_ticks = {2'b0, step_ticks_ff} + {1'b0, step_ticks_ff, 1'b0} + 18'd1;

      cur = slot_ff[emit_ff[LW-1:0]];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.cmd == CMD_RENDER) && !render_empty) begin
               state_in = S_MUL;
               phase_in = 1'b0;
               step_in  = req_data.step_sel;
               ns_in    = eff_ns;
               nl_in    = eff_nl;
               base_in  = next_id_ff + 48'd1;
               cnt_in   = '0;
               lane_in  = '0;
            end
         end
         S_MUL: begin
            if (!phase_ff) begin
               start_in = sum33[32] ? TICK_MAX : sum33[31:0];
               phase_in = 1'b1;
            end else begin
               len_in       = (glen == '0) ? LEN_W'(1) : glen;
               slide_len_in = LEN_W'(tri_ticks[17:1]);
               phase_in     = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN, S_DRAIN: begin
            if (pend_valid_ff) begin
               slot_in[0] = le[0] ? slot_ff[0] : new_slot;
               for (int i = 1; i < MAX_LANES; i++) begin
                  if (le[i]) begin
                     slot_in[i] = slot_ff[i];
                  end else if (le[i-1]) begin
                     slot_in[i] = new_slot;
                  end else begin
                     slot_in[i] = slot_ff[i-1];
                  end
               end
               cnt_in = cnt_ff + NL_W'(1);
            end
            if (state_ff == S_SCAN) begin
               pend_valid_in = row[SW'(step_ff)];
               pend_id_in    = base_ff + 48'(below_cnt);
               pend_note_in  = lane_note_ff[lane_ff[LW-1:0]];
               base_in       = base_ff + 48'(used_cnt);
               lane_in       = lane_ff + NL_W'(1);
               if (lane_ff + NL_W'(1) == nl_ff) begin
                  state_in = S_DRAIN;
               end
            end else begin
               pend_valid_in = 1'b0;
               emit_in       = '0;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_ff == cnt_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               sum33 = {1'b0, start_ff} + 33'(cur.slide ? slide_len_ff : len_ff);
               rsp_in.start_tick  = start_ff;
               rsp_in.end_tick    = sum33[32] ? TICK_MAX : sum33[31:0];
               rsp_in.channel_out = channel_ff;
               rsp_in.note_number = cur.note;
               rsp_in.velocity    = cur.accent ? accent_vel_ff : step_vel_ff;
               rsp_in.note_id     = cur.id;
               rsp_in.last        = (emit_ff + NL_W'(1) == cnt_ff);
               rsp_valid_in       = 1'b1;
               emit_in            = emit_ff + NL_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, int'(cnt_ff) <= MAX_LANES)
   `ASSERT_SAME(a_emit_bound, clock, reset, state_ff == S_EMIT, emit_ff <= cnt_ff)
   `ASSERT_NEXT(a_render_busy, clock, reset,
                req_fire && (req_data.cmd == CMD_RENDER) && !render_empty, !req_ready)

endmodule

### bench/tb_top.sv
// Testbench for the step grid to note events block: random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_top
   import sgne_pkg::*;
();

   localparam int LANES = 8;
   localparam int STEPS = 16;
   localparam logic [15:0] SLIDE_GATE = 16'd384;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   step_grid_to_note_events i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state.
   logic [15:0] ticks_per_step;
   logic [4:0]  steps_used;
   logic [31:0] pattern_base;
   logic [9:0]  gate_q8;
   logic [6:0]  accent_vel, normal_vel;
   logic [3:0]  channel;
   logic [3:0]  lanes_used;
   logic        grid_active [LANES*STEPS];
   logic        grid_accent [LANES*STEPS];
   logic        grid_slide [LANES*STEPS];
   logic [6:0]  grid_note [LANES*STEPS];
   logic [6:0]  lane_default [LANES];
   logic [47:0] id_base;

   req_type pending_words[$];
   rsp_type expected_notes[$];
   int      errors = 0;
   int      notes_seen = 0;
   longint  cycle_count = 0;
   bit      feed_enable = 1'b0;

   function automatic logic [31:0] sat32(logic [33:0] v);
      return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // Appends one word to the tail of the pending queue.
   function automatic void queue_word(req_type w);
      pending_words = {pending_words, w};
   endfunction

   // Applies one command word to the predictor and queues the notes it produces.
   task automatic predict_word(req_type w);
      int ns, nl, cnt, k, c, idx;
      logic [47:0] preceding;
      logic [6:0]  nums [LANES];
      int          lane_of [LANES];
      logic [47:0] ids [LANES];
      logic [6:0]  n;
      logic [47:0] start_t, len;
      logic [15:0] gate;
      rsp_type     r;
      cnt = 0;
      preceding = '0;
      case (cmd_type'(w.cmd))
         CMD_WRITE_CELL: begin
            c = w.lane_sel * STEPS + w.step_sel;
            grid_active[c] = w.active_in;
            grid_accent[c] = w.accent_in;
            grid_slide[c]  = w.slide_in;
            grid_note[c]   = w.note_in;
         end
         CMD_WRITE_LANE: lane_default[w.lane_sel] = w.note_in;
         CMD_LOAD_ID: id_base = w.id_value;
         CMD_RENDER: begin
            ns = (steps_used > STEPS) ? STEPS : steps_used;
            nl = (lanes_used > LANES) ? LANES : lanes_used;
            if (ticks_per_step != 0 && ns != 0 && w.step_sel < ns && nl != 0) begin
               start_t = 48'(sat32(34'(pattern_base) + 34'(w.step_sel) * 34'(ticks_per_step)));
               for (int l = 0; l < nl; l++) begin
                  for (int s = 0; s < ns; s++) begin
                     if (grid_active[l*STEPS+s]) begin
                        if (s == w.step_sel) begin
                           n = (grid_note[l*STEPS+s] != 0) ? grid_note[l*STEPS+s]
                                                           : lane_default[l];
                           k = cnt;
                           while (k > 0 && nums[k-1] > n) begin
                              nums[k] = nums[k-1];
                              lane_of[k] = lane_of[k-1];
                              ids[k] = ids[k-1];
                              k--;
                           end
                           nums[k] = n;
                           lane_of[k] = l;
                           ids[k] = id_base + 48'd1 + preceding;
                           cnt++;
                        end
                        preceding++;
                     end
                  end
               end
               for (k = 0; k < cnt; k++) begin
                  idx = lane_of[k] * STEPS + w.step_sel;
                  gate = grid_slide[idx] ? SLIDE_GATE : {6'd0, gate_q8};
                  len = (48'(ticks_per_step) * 48'(gate) + 48'd128) >> 8;
                  if (len == 0) len = 48'd1;
                  r.start_tick  = start_t[31:0];
                  r.end_tick    = sat32(start_t[33:0] + len[33:0]);
                  r.channel_out = channel;
                  r.note_number = nums[k];
                  r.velocity    = grid_accent[idx] ? accent_vel : normal_vel;
                  r.note_id     = ids[k];
                  r.last        = (k + 1 == cnt);
                  expected_notes = {expected_notes, r};
               end
            end
         end
      endcase
   endtask

   // Driver: pops pending words with a random gap after each.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (feed_enable && pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random stalls on the result side, compare each word with the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            notes_seen++;
            if (expected_notes.size() == 0) begin
               $display("%0t: unexpected word %p", $time, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = expected_notes.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  errors++;
               end
            end
            stall_left = (cycle_count % 5 == 0) ? 0 : $urandom_range(0, 9);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_word(cmd_type c, int lane, int step, bit act, bit acc,
                                         bit sld, int note, logic [47:0] idv);
      req_type w;
      w.cmd = c; w.lane_sel = 3'(lane); w.step_sel = 4'(step);
      w.active_in = act; w.accent_in = acc; w.slide_in = sld;
      w.note_in = 7'(note); w.id_value = idv;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      w = make_word(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 7),
                    $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 127),
                    48'({$urandom, $urandom}));
      // Favor cell writes and renders so the grid fills and gets played.
      if (w.cmd == CMD_LOAD_ID && $urandom_range(0, 3) != 0) w.cmd = CMD_RENDER;
      if (w.cmd == CMD_WRITE_LANE && $urandom_range(0, 1) == 0) w.cmd = CMD_WRITE_CELL;
      return w;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_STEP_TICKS:    ticks_per_step = val[15:0];
         REG_STEP_COUNT:    steps_used = val[4:0];
         REG_PATTERN_START: pattern_base = val;
         REG_GATE_RATIO:    gate_q8 = val[9:0];
         REG_ACCENT_VEL:    accent_vel = val[6:0];
         REG_STEP_VEL:      normal_vel = val[6:0];
         REG_MIDI_CHANNEL:  channel = val[3:0];
         REG_LANE_COUNT:    lanes_used = val[3:0];
      endcase
   endtask

   // Lets the queue drain and the block settle before a register write.
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_notes.size() > 0)
         @(posedge clock);
      feed_enable = 1'b0;
      repeat (30) @(posedge clock);
   endtask

   task automatic run_phase(int count);
      for (int i = 0; i < count; i++) queue_word(random_word());
      feed_enable = 1'b1;
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      ticks_per_step = 16'd120; steps_used = 5'd16; pattern_base = 32'd0; gate_q8 = 10'd230;
      accent_vel = 7'd127; normal_vel = 7'd100; channel = 4'd0; lanes_used = 4'd1;
      id_base = '0;
      for (int i = 0; i < LANES*STEPS; i++) begin
         grid_active[i] = 1'b0; grid_accent[i] = 1'b0; grid_slide[i] = 1'b0;
         grid_note[i] = 7'd0;
      end
      for (int i = 0; i < LANES; i++) lane_default[i] = 7'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset settings, then all lanes with ties, extremes and slides.
      write_reg(REG_LANE_COUNT, 32'd8);
      queue_word(make_word(CMD_WRITE_LANE, 0, 0, 0, 0, 0, 127, 0));
      queue_word(make_word(CMD_WRITE_LANE, 7, 0, 0, 0, 0, 1, 0));
      for (int l = 0; l < 8; l++)
         queue_word(make_word(CMD_WRITE_CELL, l, 15, 1, l[0], l[1],
                              (l < 2 || l == 7) ? 0 : 60 - (l % 3), 0));
      queue_word(make_word(CMD_WRITE_CELL, 3, 0, 1, 1, 1, 127, 0));
      queue_word(make_word(CMD_RENDER, 0, 15, 0, 0, 0, 0, 0));
      queue_word(make_word(CMD_RENDER, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(CMD_RENDER, 0, 5, 0, 0, 0, 0, 0));
      queue_word(make_word(CMD_LOAD_ID, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFE));
      queue_word(make_word(CMD_RENDER, 0, 15, 0, 0, 0, 0, 0));
      queue_word(make_word(CMD_LOAD_ID, 0, 0, 0, 0, 0, 0, 48'h0));
      feed_enable = 1'b1;
      wait_idle();

      // Extremes: saturating ticks, largest gate, out-of-range counts.
      write_reg(REG_STEP_TICKS, 32'hFFFF);
      write_reg(REG_PATTERN_START, 32'hFFFF_0000);
      write_reg(REG_GATE_RATIO, 32'h3FF);
      write_reg(REG_ACCENT_VEL, 32'd0);
      write_reg(REG_STEP_VEL, 32'd127);
      write_reg(REG_MIDI_CHANNEL, 32'd15);
      write_reg(REG_STEP_COUNT, 32'd31);
      write_reg(REG_LANE_COUNT, 32'd15);
      queue_word(make_word(CMD_RENDER, 0, 15, 0, 0, 0, 0, 0));
      queue_word(make_word(CMD_RENDER, 0, 0, 0, 0, 0, 0, 0));
      run_phase(50);

      // Tiny ticks with zero gate give notes without slide the minimum length of one.
      write_reg(REG_STEP_TICKS, 32'd1);
      write_reg(REG_PATTERN_START, 32'd0);
      write_reg(REG_GATE_RATIO, 32'd0);
      write_reg(REG_STEP_COUNT, 32'd4);
      write_reg(REG_LANE_COUNT, 32'd3);
      run_phase(50);

      // Nothing is emitted with zero steps, zero ticks or zero lanes.
      write_reg(REG_STEP_COUNT, 32'd0);
      run_phase(10);
      write_reg(REG_STEP_COUNT, 32'd16);
      write_reg(REG_STEP_TICKS, 32'd0);
      run_phase(10);
      write_reg(REG_STEP_TICKS, 32'd480);
      write_reg(REG_LANE_COUNT, 32'd0);
      run_phase(10);

      for (int p = 0; p < 3; p++) begin
         write_reg(REG_STEP_TICKS, $urandom_range(1, 65535));
         write_reg(REG_STEP_COUNT, $urandom_range(1, 16));
         write_reg(REG_PATTERN_START, $urandom);
         write_reg(REG_GATE_RATIO, $urandom_range(0, 1023));
         write_reg(REG_ACCENT_VEL, $urandom_range(0, 127));
         write_reg(REG_STEP_VEL, $urandom_range(0, 127));
         write_reg(REG_MIDI_CHANNEL, $urandom_range(0, 15));
         write_reg(REG_LANE_COUNT, $urandom_range(1, 8));
         run_phase(40);
      end

      repeat (50) @(posedge clock);
      $display("Covered directed extremes, empty renders and %0d result words over", notes_seen);
      $display("several register settings with random gaps and stalls.");
      if (errors == 0 && expected_notes.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
